[hw/rtl/colon_command_percent_parser_macros.svh]
// Assertion macros used by the parser RTL.
`ifndef COLON_COMMAND_PERCENT_PARSER_MACROS_SVH
`define COLON_COMMAND_PERCENT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CCPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CCPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ccpp_pkg.sv]
`timescale 1ns / 1ps

package ccpp_pkg;

	// Characters the parser looks for
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Command names, one character per position
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_R = 8'h52;

	localparam logic [2:0] LED_LEN   = 3'd3;
	localparam logic [2:0] MOTOR_LEN = 3'd5;
	localparam logic [2:0] NAME_SAT  = 3'd6;
	localparam logic [6:0] PERCENT_MAX = 7'd100;
	localparam logic [9:0] DEC_BASE    = 10'd10;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FORMAT   = 3'd2,
		ST_MISSING  = 3'd3,
		ST_UNKNOWN  = 3'd4,
		ST_NONDIGIT = 3'd5,
		ST_RANGE    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_LED   = 2'd1,
		KIND_MOTOR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		VERR_NONE     = 2'd0,
		VERR_NONDIGIT = 2'd1,
		VERR_RANGE    = 2'd2
	} verr_t;

	// Input word: one received byte plus end-of-command flag
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_message;
	} cmd_word_t;

	// Result word
	typedef struct packed {
		status_t    status;
		kind_t      command_kind;
		logic [6:0] percent;
	} rsp_word_t;

	// Parser context carried from byte to byte
	typedef struct packed {
		logic [2:0] name_chars;
		logic       led_match;
		logic       motor_match;
		logic       separator_seen;
		logic       param_present;
		logic [6:0] accum_value;
		verr_t      value_error;
		logic       held_line_end;
		logic       text_present;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		name_chars:     3'd0,
		led_match:      1'b1,
		motor_match:    1'b1,
		separator_seen: 1'b0,
		param_present:  1'b0,
		accum_value:    7'd0,
		value_error:    VERR_NONE,
		held_line_end:  1'b0,
		text_present:   1'b0
	};

endpackage

[hw/rtl/ccpp_core.sv]
`timescale 1ns / 1ps

// Parser context register and the per-byte update. Result is combinational
// and only meaningful when the stepped word carries end_of_message.
module ccpp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  ccpp_pkg::cmd_word_t  word,
	output ccpp_pkg::rsp_word_t  result
);

	ccpp_pkg::parse_state_t state_q;
	ccpp_pkg::parse_state_t after_held;
	ccpp_pkg::parse_state_t after_byte;
	ccpp_pkg::kind_t        kind;
	ccpp_pkg::status_t      status;

	// Expected character of each name at a position, zero past the end
	function automatic logic [7:0] led_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = ccpp_pkg::CH_L;
			3'd1:    ch = ccpp_pkg::CH_E;
			3'd2:    ch = ccpp_pkg::CH_D;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] motor_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = ccpp_pkg::CH_M;
			3'd1:    ch = ccpp_pkg::CH_O;
			3'd2:    ch = ccpp_pkg::CH_T;
			3'd3:    ch = ccpp_pkg::CH_O;
			3'd4:    ch = ccpp_pkg::CH_R;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Take one text character into the context
	function automatic ccpp_pkg::parse_state_t take_char(
		input ccpp_pkg::parse_state_t s,
		input logic [7:0]             c
	);
		ccpp_pkg::parse_state_t r;
		logic [7:0] digit;
		logic [9:0] val;
		r = s;
		digit = c - ccpp_pkg::CH_ZERO;
		val = 10'(s.accum_value) * ccpp_pkg::DEC_BASE + 10'(digit[3:0]);
		r.text_present = 1'b1;
		if (!s.separator_seen) begin
			if (c == ccpp_pkg::CH_COLON) begin
				r.separator_seen = 1'b1;
			end else begin
				if (!(s.name_chars < ccpp_pkg::LED_LEN && c == led_char(s.name_chars)))
					r.led_match = 1'b0;
				if (!(s.name_chars < ccpp_pkg::MOTOR_LEN && c == motor_char(s.name_chars)))
					r.motor_match = 1'b0;
				if (s.name_chars < ccpp_pkg::NAME_SAT)
					r.name_chars = s.name_chars + 3'd1;
			end
		end else begin
			r.param_present = 1'b1;
			if (s.value_error == ccpp_pkg::VERR_NONE) begin
				if (c < ccpp_pkg::CH_ZERO || c > ccpp_pkg::CH_NINE)
					r.value_error = ccpp_pkg::VERR_NONDIGIT;
				else if (val > 10'(ccpp_pkg::PERCENT_MAX))
					r.value_error = ccpp_pkg::VERR_RANGE;
				else
					r.accum_value = val[6:0];
			end
		end
		return r;
	endfunction

	// Line ends are held; a later byte releases them as one CR character
	always_comb begin
		after_held = state_q;
		after_byte = state_q;
		if (word.rx_byte == ccpp_pkg::CH_CR || word.rx_byte == ccpp_pkg::CH_LF) begin
			after_byte.held_line_end = 1'b1;
		end else begin
			if (state_q.held_line_end) begin
				after_held = take_char(state_q, ccpp_pkg::CH_CR);
				after_held.held_line_end = 1'b0;
			end
			after_byte = take_char(after_held, word.rx_byte);
		end
	end

	// Final-byte verdict, in ranked order
	always_comb begin
		if (after_byte.led_match && after_byte.name_chars == ccpp_pkg::LED_LEN)
			kind = ccpp_pkg::KIND_LED;
		else if (after_byte.motor_match && after_byte.name_chars == ccpp_pkg::MOTOR_LEN)
			kind = ccpp_pkg::KIND_MOTOR;
		else
			kind = ccpp_pkg::KIND_NONE;

		if (!after_byte.text_present)
			status = ccpp_pkg::ST_EMPTY;
		else if (!after_byte.separator_seen || after_byte.name_chars == 3'd0)
			status = ccpp_pkg::ST_FORMAT;
		else if (!after_byte.param_present)
			status = ccpp_pkg::ST_MISSING;
		else if (kind == ccpp_pkg::KIND_NONE)
			status = ccpp_pkg::ST_UNKNOWN;
		else if (after_byte.value_error == ccpp_pkg::VERR_NONDIGIT)
			status = ccpp_pkg::ST_NONDIGIT;
		else if (after_byte.value_error == ccpp_pkg::VERR_RANGE)
			status = ccpp_pkg::ST_RANGE;
		else
			status = ccpp_pkg::ST_OK;

		result.status = status;
		if (status == ccpp_pkg::ST_OK) begin
			result.command_kind = kind;
			result.percent      = after_byte.accum_value;
		end else begin
			result.command_kind = ccpp_pkg::KIND_NONE;
			result.percent      = 7'd0;
		end
	end

	// Context register; the final byte returns it to the reset context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccpp_pkg::STATE_RESET;
		end else if (step) begin
			if (word.end_of_message)
				state_q <= ccpp_pkg::STATE_RESET;
			else
				state_q <= after_byte;
		end
	end

endmodule

[hw/rtl/colon_command_percent_parser.sv]
`timescale 1ns / 1ps
// Streaming parser for NAME:VALUE commands (NAME is LED or MOTOR, VALUE 0..100).
// cmd channel: one byte per word, end_of_message set on the last byte.
// rsp channel: one word per command (status, command_kind, percent), sent
// only for the last byte; other bytes produce nothing.
// Throughput: one byte per cycle, held up only when a final byte finds the result
// register busy; the context update between the two registers is combinational.
// Path: the final byte lands in the input register when it is accepted, and
// its result word is captured in the result register when that byte steps on.
// Reset: arst_n clears the valid flags of the input and result registers and
// the parser context; the block takes bytes right after reset is released.
// Receiver stall: ordinary bytes keep flowing while a result waits. A final
// byte that finds the result register still occupied waits in the input
// register and cmd_ready drops until the pending result is taken.
module colon_command_percent_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ccpp_pkg::cmd_word_t cmd_word,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ccpp_pkg::rsp_word_t rsp_word
);

	`include "colon_command_percent_parser_macros.svh"

	logic                valid_s1;
	ccpp_pkg::cmd_word_t word_s1;
	logic                step;
	ccpp_pkg::rsp_word_t result;
	logic                rsp_valid_q;
	ccpp_pkg::rsp_word_t rsp_q;

	// A byte moves on unless it is final and the result slot is busy
	assign step      = valid_s1 && (!word_s1.end_of_message || !rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			word_s1 <= cmd_word;
	end

	ccpp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (word_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step && word_s1.end_of_message) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && word_s1.end_of_message)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// Checks
	`CCPP_ASSERT_NOW(a_err_clears_payload,
		rsp_valid && rsp_word.status != ccpp_pkg::ST_OK,
		rsp_word.command_kind == ccpp_pkg::KIND_NONE && rsp_word.percent == 7'd0,
		"error result carries kind or percent")
	`CCPP_ASSERT_NOW(a_ok_is_sane,
		rsp_valid && rsp_word.status == ccpp_pkg::ST_OK,
		rsp_word.command_kind != ccpp_pkg::KIND_NONE
			&& rsp_word.percent <= ccpp_pkg::PERCENT_MAX,
		"ok result without kind or with percent above limit")
	`CCPP_ASSERT_NEXT(a_final_held,
		valid_s1 && !step,
		valid_s1 && $stable(word_s1),
		"held byte lost from input register")
	`CCPP_ASSERT_NEXT(a_final_lands,
		step && word_s1.end_of_message,
		rsp_valid,
		"final byte produced no result")

endmodule

[verif/colon_command_percent_parser_tb.sv]
`timescale 1ns / 1ps

module colon_command_percent_parser_tb;

	import ccpp_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int IDLE_LIMIT   = 5000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_word_t  cmd_word;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_word_t  rsp_word;

	// Predictor context and the results it still owes
	parse_state_t parse_ctx = STATE_RESET;
	rsp_word_t    expected_results[$];
	rsp_word_t    predicted;

	logic [7:0] cmd_bytes[$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         hold_req = 1'b0;
	int         mismatch_count = 0;
	int         quiet_cycles = 0;

	colon_command_percent_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Command predictor
	// ---------------------------------------------------------------
	function automatic logic [7:0] led_letter(input logic [2:0] pos);
		case (pos)
			3'd0: return CH_L;
			3'd1: return CH_E;
			default: return CH_D;
		endcase
	endfunction

	function automatic logic [7:0] motor_letter(input logic [2:0] pos);
		case (pos)
			3'd0: return CH_M;
			3'd1: return CH_O;
			3'd2: return CH_T;
			3'd3: return CH_O;
			default: return CH_R;
		endcase
	endfunction

	// Fold one text character into the parse context
	function automatic void absorb_char(input logic [7:0] c);
		int unsigned next_value;
		parse_ctx.text_present = 1'b1;
		if (!parse_ctx.separator_seen) begin
			if (c == CH_COLON) begin
				parse_ctx.separator_seen = 1'b1;
				return;
			end
			if (!(parse_ctx.name_chars < LED_LEN && c == led_letter(parse_ctx.name_chars)))
				parse_ctx.led_match = 1'b0;
			if (!(parse_ctx.name_chars < MOTOR_LEN && c == motor_letter(parse_ctx.name_chars)))
				parse_ctx.motor_match = 1'b0;
			if (parse_ctx.name_chars < NAME_SAT)
				parse_ctx.name_chars = parse_ctx.name_chars + 3'd1;
			return;
		end
		parse_ctx.param_present = 1'b1;
		if (parse_ctx.value_error != VERR_NONE)
			return;
		if (c < CH_ZERO || c > CH_NINE) begin
			parse_ctx.value_error = VERR_NONDIGIT;
			return;
		end
		next_value = int'(parse_ctx.accum_value) * 10 + int'(c) - int'(CH_ZERO);
		if (next_value > int'(PERCENT_MAX))
			parse_ctx.value_error = VERR_RANGE;
		else
			parse_ctx.accum_value = 7'(next_value);
	endfunction

	// Returns 1 when the word closes a command; res then holds the outcome
	function automatic bit predict_word(input cmd_word_t w, output rsp_word_t res);
		kind_t   kind;
		status_t st;
		res = '0;
		if (w.rx_byte == CH_CR || w.rx_byte == CH_LF) begin
			parse_ctx.held_line_end = 1'b1;
		end else begin
			// held line ends turn out to be inside the text
			if (parse_ctx.held_line_end) begin
				absorb_char(CH_CR);
				parse_ctx.held_line_end = 1'b0;
			end
			absorb_char(w.rx_byte);
		end
		if (!w.end_of_message)
			return 1'b0;

		kind = KIND_NONE;
		if (parse_ctx.led_match && parse_ctx.name_chars == LED_LEN)
			kind = KIND_LED;
		else if (parse_ctx.motor_match && parse_ctx.name_chars == MOTOR_LEN)
			kind = KIND_MOTOR;

		if (!parse_ctx.text_present)
			st = ST_EMPTY;
		else if (!parse_ctx.separator_seen || parse_ctx.name_chars == 3'd0)
			st = ST_FORMAT;
		else if (!parse_ctx.param_present)
			st = ST_MISSING;
		else if (kind == KIND_NONE)
			st = ST_UNKNOWN;
		else if (parse_ctx.value_error == VERR_NONDIGIT)
			st = ST_NONDIGIT;
		else if (parse_ctx.value_error == VERR_RANGE)
			st = ST_RANGE;
		else
			st = ST_OK;

		res.status = st;
		res.command_kind = (st == ST_OK) ? kind : KIND_NONE;
		res.percent = (st == ST_OK) ? parse_ctx.accum_value : 7'd0;
		parse_ctx = STATE_RESET;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: result check, prediction, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n) begin
			// check first so a word predicted this edge cannot mask a stray result
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word status=%0d kind=%0d percent=%0d",
						$time, rsp_word.status, rsp_word.command_kind, rsp_word.percent);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_word.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp_word.status);
						mismatch_count++;
					end
					if (rsp_word.command_kind !== want.command_kind) begin
						$display("%0t: command_kind expected %0d actual %0d",
							$time, want.command_kind, rsp_word.command_kind);
						mismatch_count++;
					end
					if (rsp_word.percent !== want.percent) begin
						$display("%0t: percent expected %0d actual %0d",
							$time, want.percent, rsp_word.percent);
						mismatch_count++;
					end
				end
			end

			if (cmd_valid && cmd_ready) begin
				if (predict_word(cmd_word, predicted))
					expected_results.push_back(predicted);
			end

			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("colon_command_percent_parser: mismatch");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result side: random backpressure plus the long hold-off
	// ---------------------------------------------------------------
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Command side
	// ---------------------------------------------------------------
	// Offer one word; returns right after the edge that takes it
	task automatic send_word(input logic [7:0] b, input logic eom);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_word  <= {b, eom};
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		cmd_valid <= 1'b0;
	endtask

	// Send the staged bytes, flagging the last as end of message
	task automatic send_command(inout int byte_count);
		foreach (cmd_bytes[i]) begin
			send_word(cmd_bytes[i], i == cmd_bytes.size() - 1);
			byte_count++;
		end
		cmd_bytes.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			cmd_bytes.push_back(s[i]);
	endtask

	task automatic queue_number(input int unsigned value);
		if (value >= 100)
			cmd_bytes.push_back(CH_ZERO + 8'((value / 100) % 10));
		if (value >= 10)
			cmd_bytes.push_back(CH_ZERO + 8'((value / 10) % 10));
		cmd_bytes.push_back(CH_ZERO + 8'(value % 10));
	endtask

	function automatic logic [7:0] line_end();
		return $urandom_range(1) ? CH_CR : CH_LF;
	endfunction

	// Stage one random command: mostly well formed, some broken, some noise
	task automatic build_random_command();
		int unsigned pick;
		int unsigned idx;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if ($urandom_range(1))
				queue_text("LED");
			else
				queue_text("MOTOR");
			// occasionally spoil the name
			if ($urandom_range(9) == 0) begin
				idx = $urandom_range(cmd_bytes.size() - 1);
				case ($urandom_range(2))
					0: cmd_bytes[idx] = 8'($urandom_range(255));
					1: void'(cmd_bytes.pop_back());
					default: cmd_bytes.push_back(8'($urandom_range(255)));
				endcase
			end
			if ($urandom_range(19) == 0)
				cmd_bytes.push_back(line_end());
			cmd_bytes.push_back(CH_COLON);
			if ($urandom_range(9) == 0)
				cmd_bytes.push_back(CH_ZERO);
			if ($urandom_range(4) == 0)
				queue_number($urandom_range(999, 101));
			else
				queue_number($urandom_range(100));
			// a stray byte, a line end or extra digits inside the value
			case ($urandom_range(9))
				0: begin
					cmd_bytes.push_back(8'($urandom_range(255)));
					queue_number($urandom_range(9));
				end
				1: begin
					cmd_bytes.push_back(line_end());
					queue_number($urandom_range(9));
				end
				2: queue_number($urandom_range(99));
				default: ;
			endcase
			repeat ($urandom_range(2)) cmd_bytes.push_back(line_end());
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: repeat ($urandom_range(3, 1)) cmd_bytes.push_back(line_end());
				1: begin
					if ($urandom_range(1))
						queue_text("LED");
					else
						queue_text("MOTOR");
					if ($urandom_range(1))
						queue_number($urandom_range(100));
				end
				2: begin
					if ($urandom_range(1))
						queue_text("LED:");
					else
						queue_text("MOTOR:");
					repeat ($urandom_range(2)) cmd_bytes.push_back(line_end());
				end
				default: begin
					cmd_bytes.push_back(CH_COLON);
					queue_number($urandom_range(100));
				end
			endcase
		end else begin
			repeat ($urandom_range(8, 1)) cmd_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_for_results();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// One command per status, plus line end and colon corner cases
	task automatic test_directed_commands();
		int sent;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// line ends only: empty
		cmd_bytes.push_back(CH_CR);
		send_command(sent);
		// colon as the very first character
		queue_text(":");
		send_command(sent);
		// no colon, all-ones byte
		cmd_bytes.push_back(8'hFF);
		send_command(sent);
		// nothing after the colon
		queue_text("D:");
		send_command(sent);
		// zero byte as name
		cmd_bytes.push_back(8'h00);
		queue_text(":7");
		send_command(sent);
		// top of range
		queue_text("MOTOR:100");
		send_command(sent);
		// trailing line ends are dropped
		queue_text("LED:0");
		cmd_bytes.push_back(CH_CR);
		cmd_bytes.push_back(CH_LF);
		send_command(sent);
		queue_text("LED:101");
		send_command(sent);
		// held line end released inside the value
		queue_text("LED:");
		cmd_bytes.push_back(CH_LF);
		queue_text("5");
		send_command(sent);
		// second colon counts as a non-digit
		queue_text("LED:1:");
		send_command(sent);
		stop_sending();
		wait_for_results();
	endtask

	// Result side blocks for a long stretch while commands keep coming
	task automatic test_receiver_hold_off();
		int sent;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (8) begin
			if ($urandom_range(1))
				queue_text("LED:");
			else
				queue_text("MOTOR:");
			queue_number($urandom_range(100));
			send_command(sent);
		end
		stop_sending();
		wait_for_results();
	endtask

	task automatic test_random_commands(input int send_pct, input int recv_pct,
		input int byte_budget);
		int sent;
		sent = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < byte_budget) begin
			build_random_command();
			send_command(sent);
		end
		stop_sending();
		wait_for_results();
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_word  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_commands();
		test_receiver_hold_off();
		test_random_commands(20, 70, 180);
		test_random_commands(70, 20, 180);
		test_random_commands(0, 0, 180);

		if (mismatch_count == 0)
			$display("colon_command_percent_parser: match");
		else
			$display("colon_command_percent_parser: mismatch");
		$finish;
	end

endmodule
